// File: src/mdfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mdfs_pkg;

  // Index width that holds any legal row or column of the mask
  localparam int IDX_W   = 12;
  // Signed width for clipping arithmetic on coordinates and bounds
  localparam int COORD_W = 14;
  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [1:0] {
    ACT_START     = 2'd0,
    ACT_FEATURE   = 2'd1,
    ACT_CANDIDATE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_ROWS_USED    = 2'd0,
    CFG_COLS_USED    = 2'd1,
    CFG_MIN_DISTANCE = 2'd2,
    CFG_NEEDED_COUNT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  rows_used;
    logic [9:0]  cols_used;
    logic [4:0]  min_distance;
    logic [10:0] needed_count;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [1:0] action;
    logic       in_area;
    logic       empty;
    idx_t       r0;
    idx_t       r1;
    idx_t       c0;
    idx_t       c1;
    idx_t       row;
    idx_t       col;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_FILL,
    BK_IDLE,
    BK_CHECK,
    BK_CLEAR
  } bk_state_t;

endpackage

`default_nettype wire

// File: src/mdfs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mdfs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [11:0] point_row;
  logic signed [11:0] point_col;

  modport source (output valid, output action, output point_row, output point_col,
                  input ready);
  modport sink (input valid, input action, input point_row, input point_col,
                output ready);
endinterface

`default_nettype wire

// File: src/mdfs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mdfs_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        finished;
  logic [10:0] feature_count;

  modport source (output valid, output accepted, output finished, output feature_count,
                  input ready);
  modport sink (input valid, input accepted, input finished, input feature_count,
                output ready);
endinterface

`default_nettype wire

// File: src/mdfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mdfs_ram #(
  parameter int WIDTH = 512,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/mdfs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mdfs_front #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  wire logic          hold,
  input  wire mdfs_pkg::cfg_t cfg,
  mdfs_in_if.sink            item,
  input  wire logic          q_full,
  output logic               push,
  output mdfs_pkg::cmd_t     cmd
);

  mdfs_pkg::coord_t prow, pcol, radius, nrows, ncols;
  mdfs_pkg::coord_t rlo, rhi, clo, chi;

  // Take a transaction whenever the queue has room and hold is low
  assign item.ready = !hold && !q_full;
  assign push       = item.valid && item.ready;

  // Clip the square to the active area and test the point
  always_comb begin
    prow   = mdfs_pkg::coord_t'(item.point_row);
    pcol   = mdfs_pkg::coord_t'(item.point_col);
    radius = mdfs_pkg::coord_t'(cfg.min_distance);
    nrows  = (cfg.rows_used < MAX_ROWS) ? mdfs_pkg::coord_t'(cfg.rows_used)
                                        : mdfs_pkg::coord_t'(MAX_ROWS);
    ncols  = (cfg.cols_used < MAX_COLS) ? mdfs_pkg::coord_t'(cfg.cols_used)
                                        : mdfs_pkg::coord_t'(MAX_COLS);

    rlo = prow - radius;
    if (rlo < 0) rlo = '0;
    rhi = prow + radius;
    if (rhi > nrows - mdfs_pkg::coord_t'(1)) rhi = nrows - mdfs_pkg::coord_t'(1);
    clo = pcol - radius;
    if (clo < 0) clo = '0;
    chi = pcol + radius;
    if (chi > ncols - mdfs_pkg::coord_t'(1)) chi = ncols - mdfs_pkg::coord_t'(1);

    cmd.action  = item.action;
    cmd.empty   = (rlo > rhi) || (clo > chi);
    cmd.in_area = (prow >= 0) && (prow < nrows) && (pcol >= 0) && (pcol < ncols);
    cmd.r0      = mdfs_pkg::idx_t'(rlo);
    cmd.r1      = mdfs_pkg::idx_t'(rhi);
    cmd.c0      = mdfs_pkg::idx_t'(clo);
    cmd.c1      = mdfs_pkg::idx_t'(chi);
    cmd.row     = mdfs_pkg::idx_t'(prow);
    cmd.col     = mdfs_pkg::idx_t'(pcol);
  end

endmodule

`default_nettype wire

// File: src/mdfs_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mdfs_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mdfs_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output mdfs_pkg::cmd_t      q_cmd
);

  localparam int PW = $clog2(mdfs_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mdfs_pkg::QUEUE_DEPTH + 1);

  mdfs_pkg::cmd_t entry [mdfs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  fill;

  assign full    = (fill == CW'(mdfs_pkg::QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_cmd   = entry[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(mdfs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(mdfs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/mdfs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mdfs_back #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mdfs_pkg::count_t        needed_count,
  input  wire logic                    q_valid,
  input  wire mdfs_pkg::cmd_t          q_cmd,
  output logic                         pop,
  output logic                         init_busy,
  mdfs_out_if.source                   result
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  mdfs_pkg::bk_state_t state, state_next;
  mdfs_pkg::count_t    count, count_next, count_sat;
  logic                done, done_next;
  logic                post_fill, post_fill_next;
  logic [RW-1:0]       fill_row, fill_row_next;
  logic [RW-1:0]       cur_row, cur_row_next;
  logic [RW-1:0]       last_row, last_row_next;
  logic [RW-1:0]       pend_row, pend_row_next;
  logic                rd_act, rd_act_next;
  logic                pend, pend_next;
  logic                in_area, in_area_next;
  logic [CW-1:0]       col, col_next;
  logic [MAX_COLS-1:0] colmask, colmask_next, colmask_new;
  logic                res_valid, res_valid_next;
  logic                res_accepted, res_accepted_next;

  logic                wr_en, rd_en;
  logic [RW-1:0]       wr_addr, rd_addr;
  logic [MAX_COLS-1:0] wr_data, rd_data;

  mdfs_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_mask (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign result.valid         = res_valid;
  assign result.accepted      = res_accepted;
  assign result.finished      = done;
  assign result.feature_count = count;
  assign init_busy            = (state == mdfs_pkg::BK_FILL) && !post_fill;
  assign count_sat = (count == mdfs_pkg::COUNT_MAX) ? count
                                                    : count + mdfs_pkg::count_t'(1);

  // Build the column mask of the square from its clipped bounds
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      colmask_new[j] = (mdfs_pkg::idx_t'(j) >= q_cmd.c0) &&
                       (mdfs_pkg::idx_t'(j) <= q_cmd.c1);
    end
  end

  // Hold state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mdfs_pkg::BK_FILL;
      count     <= '0;
      done      <= 1'b0;
      post_fill <= 1'b0;
      fill_row  <= '0;
      rd_act    <= 1'b0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      done      <= done_next;
      post_fill <= post_fill_next;
      fill_row  <= fill_row_next;
      rd_act    <= rd_act_next;
      pend      <= pend_next;
      res_valid <= res_valid_next;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    cur_row      <= cur_row_next;
    last_row     <= last_row_next;
    pend_row     <= pend_row_next;
    in_area      <= in_area_next;
    col          <= col_next;
    colmask      <= colmask_next;
    res_accepted <= res_accepted_next;
  end

  // Sequence each command: fill, candidate check, row-by-row clearing
  always_comb begin
    state_next        = state;
    count_next        = count;
    done_next         = done;
    post_fill_next    = post_fill;
    fill_row_next     = fill_row;
    cur_row_next      = cur_row;
    last_row_next     = last_row;
    pend_row_next     = pend_row;
    rd_act_next       = rd_act;
    pend_next         = pend;
    in_area_next      = in_area;
    col_next          = col;
    colmask_next      = colmask;
    res_accepted_next = res_accepted;
    res_valid_next    = res_valid && !result.ready;
    pop               = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = pend_row;
    wr_data           = rd_data & ~colmask;
    rd_en             = 1'b0;
    rd_addr           = cur_row;

    unique case (state)
      mdfs_pkg::BK_FILL: begin
        wr_en         = 1'b1;
        wr_addr       = fill_row;
        wr_data       = '1;
        fill_row_next = fill_row + RW'(1);
        if (fill_row == RW'(MAX_ROWS - 1)) begin
          state_next = mdfs_pkg::BK_IDLE;
          if (post_fill) begin
            res_valid_next    = 1'b1;
            res_accepted_next = 1'b0;
          end
        end
      end

      mdfs_pkg::BK_IDLE: begin
        if (q_valid && !res_valid) begin
          pop               = 1'b1;
          res_accepted_next = 1'b0;
          cur_row_next      = q_cmd.r0[RW-1:0];
          last_row_next     = q_cmd.r1[RW-1:0];
          in_area_next      = q_cmd.in_area;
          col_next          = q_cmd.col[CW-1:0];
          colmask_next      = colmask_new;
          unique case (q_cmd.action)
            mdfs_pkg::ACT_START: begin
              count_next     = '0;
              done_next      = 1'b0;
              fill_row_next  = '0;
              post_fill_next = 1'b1;
              state_next     = mdfs_pkg::BK_FILL;
            end
            mdfs_pkg::ACT_FEATURE: begin
              count_next = count_sat;
              if (q_cmd.empty) begin
                res_valid_next = 1'b1;
              end else begin
                rd_act_next = 1'b1;
                pend_next   = 1'b0;
                state_next  = mdfs_pkg::BK_CLEAR;
              end
            end
            mdfs_pkg::ACT_CANDIDATE: begin
              rd_en      = 1'b1;
              rd_addr    = q_cmd.row[RW-1:0];
              state_next = mdfs_pkg::BK_CHECK;
            end
            default: begin
              res_valid_next = 1'b1;
            end
          endcase
        end
      end

      mdfs_pkg::BK_CHECK: begin
        if (!done && in_area && rd_data[col]) begin
          count_next        = count_sat;
          res_accepted_next = 1'b1;
          if (count_sat >= needed_count) begin
            done_next      = 1'b1;
            res_valid_next = 1'b1;
            state_next     = mdfs_pkg::BK_IDLE;
          end else begin
            rd_act_next = 1'b1;
            pend_next   = 1'b0;
            state_next  = mdfs_pkg::BK_CLEAR;
          end
        end else begin
          res_valid_next = 1'b1;
          state_next     = mdfs_pkg::BK_IDLE;
        end
      end

      mdfs_pkg::BK_CLEAR: begin
        // Read one row ahead while writing back the row read last cycle
        if (rd_act) begin
          rd_en = 1'b1;
          if (cur_row == last_row) begin
            rd_act_next = 1'b0;
          end else begin
            cur_row_next = cur_row + RW'(1);
          end
        end
        pend_next     = rd_act;
        pend_row_next = cur_row;
        if (pend) begin
          wr_en = 1'b1;
        end
        if (!rd_act && !pend) begin
          res_valid_next = 1'b1;
          state_next     = mdfs_pkg::BK_IDLE;
        end
      end

      default: begin
        state_next = mdfs_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/min_distance_feature_selector_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Greedy minimum-distance feature selector over a MAX_ROWS x MAX_COLS one-bit
// allowed mask held in a RAM with one mask row per word. Each item gives one
// result. The front clips the square and queues up to two items; the back
// carries them out one at a time and starts the next only once the previous
// result has been taken. Clearing a square reads and writes one mask row per
// cycle, pipelined, for an existing feature and for an accepted candidate that
// does not finish the selection. A start item re-arms the mask with a sweep
// that sets every row. After reset the same sweep runs, during which no item
// is taken; configuration writes are taken at any time.
module min_distance_feature_selector_top #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  mdfs_in_if.sink          item,
  mdfs_out_if.source       result
);

  mdfs_pkg::cfg_t cfg;
  mdfs_pkg::cmd_t push_cmd, q_cmd;
  logic           push, q_full, pop, q_valid, init_busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_used    <= 10'd480;
      cfg.cols_used    <= 10'd512;
      cfg.min_distance <= 5'd10;
      cfg.needed_count <= 11'd150;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdfs_pkg::CFG_ROWS_USED:    cfg.rows_used    <= cfg_data[9:0];
        mdfs_pkg::CFG_COLS_USED:    cfg.cols_used    <= cfg_data[9:0];
        mdfs_pkg::CFG_MIN_DISTANCE: cfg.min_distance <= cfg_data[4:0];
        mdfs_pkg::CFG_NEEDED_COUNT: cfg.needed_count <= cfg_data;
        default: ;
      endcase
    end
  end

  mdfs_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .hold   (init_busy),
    .cfg    (cfg),
    .item   (item),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  mdfs_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  mdfs_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .needed_count (cfg.needed_count),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .init_busy    (init_busy),
    .result       (result)
  );

endmodule

`default_nettype wire
